[hdl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the stable priority queue
// Depth, count width, command and status codes, and the control word that is
// broadcast to every cell of the sorted chain.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Number of cells in the chain.
	localparam int QUEUE_DEPTH = 16;
	// Count register wide enough to hold QUEUE_DEPTH itself.
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int TAG_W = 16;
	localparam int CAT_W = 3;
	localparam int OUT_CNT_W = 5;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_POP    = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_IGNORE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Operation that every cell performs.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT,
		CELL_ROTATE
	} cell_op_t;

	typedef enum logic {
		S_IDLE,
		S_SEARCH
	} state_t;

	// Control word broadcast along the chain.
	typedef struct packed {
		cell_op_t           op;
		logic [TAG_W-1:0]   new_tag;
		logic [CAT_W-1:0]   new_cat;
	} cell_ctl_t;

	// Entry count as shown on the result port, taken modulo 32.
	function automatic logic [OUT_CNT_W-1:0] out_count(input logic [CNT_W-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return w[OUT_CNT_W-1:0];
	endfunction

endpackage

[hdl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry and, each cycle, keeps it or takes the new entry or the
// entry of a neighbor, as the broadcast control word decides.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic                         clk,
	input  spq_pkg::cell_ctl_t           ctl,
	input  logic                         occ,
	input  logic                         last,
	input  logic                         left_move,
	input  logic [spq_pkg::TAG_W-1:0]    left_tag,
	input  logic [spq_pkg::CAT_W-1:0]    left_cat,
	input  logic [spq_pkg::TAG_W-1:0]    right_tag,
	input  logic [spq_pkg::CAT_W-1:0]    right_cat,
	input  logic [spq_pkg::TAG_W-1:0]    head_tag,
	input  logic [spq_pkg::CAT_W-1:0]    head_cat,
	output logic [spq_pkg::TAG_W-1:0]    tag,
	output logic [spq_pkg::CAT_W-1:0]    cat,
	output logic                         move
);

	logic [spq_pkg::TAG_W-1:0] tag_q;
	logic [spq_pkg::CAT_W-1:0] cat_q;
	logic [spq_pkg::TAG_W-1:0] tag_d;
	logic [spq_pkg::CAT_W-1:0] cat_d;

	// The entry here must make room when the slot is free or its category is
	// above the new one; equal categories stay ahead of the newcomer.
	assign move = !occ || (cat_q > ctl.new_cat);

	// Next content of the slot.
	always_comb begin
		tag_d = tag_q;
		cat_d = cat_q;
		unique case (ctl.op)
			spq_pkg::CELL_HOLD: begin
			end
			spq_pkg::CELL_INSERT: begin
				if (move && left_move) begin
					tag_d = left_tag;
					cat_d = left_cat;
				end else if (move) begin
					tag_d = ctl.new_tag;
					cat_d = ctl.new_cat;
				end
			end
			spq_pkg::CELL_SHIFT: begin
				tag_d = right_tag;
				cat_d = right_cat;
			end
			spq_pkg::CELL_ROTATE: begin
				if (last) begin
					tag_d = head_tag;
					cat_d = head_cat;
				end else begin
					tag_d = right_tag;
					cat_d = right_cat;
				end
			end
			default: begin
			end
		endcase
	end

	// Payload register, no reset needed.
	always_ff @(posedge clk) begin
		tag_q <= tag_d;
		cat_q <= cat_d;
	end

	assign tag = tag_q;
	assign cat = cat_q;

endmodule

[hdl/stable_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue_top: bounded priority queue kept sorted in a cell chain
// Entries sit in ascending category, equal categories in arrival order.
// Insert and pop reshuffle the whole chain at once; search rotates the
// held entries past the head and watches the head for the first tag match.
//
// Channel   Direction  Handshake              Payload
// command   in         start high, busy low   command, entry_tag, category
// result    out        done, one cycle        status, out_tag, out_category,
//                                             entry_count
//
// Insert, pop, an empty search and the unused command show their result in the
// cycle after the accepting edge, and busy stays low.
// A search of a queue holding N entries rotates the chain N times with busy
// high and shows its result in the same cycle as busy falls.
// Reset empties the queue at once; slot contents are left as they are.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module stable_priority_queue_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       command,
	input  logic [spq_pkg::TAG_W-1:0]        entry_tag,
	input  logic [spq_pkg::CAT_W-1:0]        category,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [spq_pkg::TAG_W-1:0]        out_tag,
	output logic [spq_pkg::CAT_W-1:0]        out_category,
	output logic [spq_pkg::OUT_CNT_W-1:0]    entry_count
);

	localparam int D = spq_pkg::QUEUE_DEPTH;

	// Control state.
	spq_pkg::state_t              state_q, state_d;
	logic [spq_pkg::CNT_W-1:0]    count_q, count_d;
	logic [spq_pkg::CNT_W-1:0]    step_q, step_d;
	logic                         found_q, found_d;
	logic [spq_pkg::TAG_W-1:0]    key_q, key_d;
	logic [spq_pkg::TAG_W-1:0]    hit_tag_q, hit_tag_d;
	logic [spq_pkg::CAT_W-1:0]    hit_cat_q, hit_cat_d;

	// Result register.
	logic                         done_q, done_d;
	spq_pkg::status_t             status_q, status_d;
	logic [spq_pkg::TAG_W-1:0]    out_tag_q, out_tag_d;
	logic [spq_pkg::CAT_W-1:0]    out_cat_q, out_cat_d;
	logic [spq_pkg::CNT_W-1:0]    out_cnt_q, out_cnt_d;

	spq_pkg::cell_ctl_t           ctl;
	logic [spq_pkg::TAG_W-1:0]    cell_tag [D];
	logic [spq_pkg::CAT_W-1:0]    cell_cat [D];
	logic [D-1:0]                 cell_move;
	logic [D-1:0]                 cell_occ;
	logic [D-1:0]                 cell_last;

	logic                         accept;
	logic                         empty;
	logic                         full;
	logic                         head_hit;
	spq_pkg::cmd_t                cmd;

	assign accept   = start && !busy;
	assign cmd      = spq_pkg::cmd_t'(command);
	assign empty    = (count_q == '0);
	assign full     = (count_q == spq_pkg::CNT_W'(D));
	assign head_hit = (cell_tag[0] == key_q);

	// Chain of cells; occupancy and the end of the held run come from the count.
	for (genvar i = 0; i < D; i++) begin : g_cell
		logic                       lm;
		logic [spq_pkg::TAG_W-1:0]  lt, rt;
		logic [spq_pkg::CAT_W-1:0]  lc, rc;

		assign cell_occ[i]  = (spq_pkg::CNT_W'(i) < count_q);
		assign cell_last[i] = (spq_pkg::CNT_W'(i) == count_q - spq_pkg::CNT_W'(1));

		if (i == 0) begin : g_first
			assign lm = 1'b0;
			assign lt = ctl.new_tag;
			assign lc = ctl.new_cat;
		end else begin : g_mid
			assign lm = cell_move[i-1];
			assign lt = cell_tag[i-1];
			assign lc = cell_cat[i-1];
		end

		if (i == D - 1) begin : g_end
			assign rt = '0;
			assign rc = '0;
		end else begin : g_inner
			assign rt = cell_tag[i+1];
			assign rc = cell_cat[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (cell_occ[i]),
			.last      (cell_last[i]),
			.left_move (lm),
			.left_tag  (lt),
			.left_cat  (lc),
			.right_tag (rt),
			.right_cat (rc),
			.head_tag  (cell_tag[0]),
			.head_cat  (cell_cat[0]),
			.tag       (cell_tag[i]),
			.cat       (cell_cat[i]),
			.move      (cell_move[i])
		);
	end

	// Next state, chain control and result.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		step_d    = step_q;
		found_d   = found_q;
		key_d     = key_q;
		hit_tag_d = hit_tag_q;
		hit_cat_d = hit_cat_q;
		done_d    = 1'b0;
		status_d  = status_q;
		out_tag_d = out_tag_q;
		out_cat_d = out_cat_q;
		out_cnt_d = out_cnt_q;
		ctl.op      = spq_pkg::CELL_HOLD;
		ctl.new_tag = entry_tag;
		ctl.new_cat = category;
		busy        = 1'b0;

		unique case (state_q)
			spq_pkg::S_IDLE: begin
				if (accept) begin
					done_d    = 1'b1;
					status_d  = spq_pkg::ST_OK;
					out_tag_d = '0;
					out_cat_d = '0;
					out_cnt_d = count_q;
					unique case (cmd)
						spq_pkg::CMD_INSERT: begin
							if (full) begin
								status_d = spq_pkg::ST_FULL;
							end else begin
								ctl.op    = spq_pkg::CELL_INSERT;
								count_d   = count_q + spq_pkg::CNT_W'(1);
								out_cnt_d = count_d;
							end
						end
						spq_pkg::CMD_POP: begin
							if (empty) begin
								status_d = spq_pkg::ST_EMPTY;
							end else begin
								ctl.op    = spq_pkg::CELL_SHIFT;
								out_tag_d = cell_tag[0];
								out_cat_d = cell_cat[0];
								count_d   = count_q - spq_pkg::CNT_W'(1);
								out_cnt_d = count_d;
							end
						end
						spq_pkg::CMD_SEARCH: begin
							if (empty) begin
								status_d = spq_pkg::ST_EMPTY;
							end else begin
								done_d  = 1'b0;
								state_d = spq_pkg::S_SEARCH;
								step_d  = '0;
								found_d = 1'b0;
								key_d   = entry_tag;
							end
						end
						spq_pkg::CMD_IGNORE: begin
						end
						default: begin
						end
					endcase
				end
			end
			spq_pkg::S_SEARCH: begin
				// One held entry passes the head each cycle; N steps restore order.
				busy   = 1'b1;
				ctl.op = spq_pkg::CELL_ROTATE;
				if (head_hit && !found_q) begin
					found_d   = 1'b1;
					hit_tag_d = cell_tag[0];
					hit_cat_d = cell_cat[0];
				end
				step_d = step_q + spq_pkg::CNT_W'(1);
				if (step_q == count_q - spq_pkg::CNT_W'(1)) begin
					state_d   = spq_pkg::S_IDLE;
					done_d    = 1'b1;
					out_cnt_d = count_q;
					if (found_d) begin
						status_d  = spq_pkg::ST_OK;
						out_tag_d = hit_tag_d;
						out_cat_d = hit_cat_d;
					end else begin
						status_d  = spq_pkg::ST_NOT_FOUND;
						out_tag_d = '0;
						out_cat_d = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
			count_q <= '0;
			step_q  <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			step_q  <= step_d;
			found_q <= found_d;
			done_q  <= done_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		key_q     <= key_d;
		hit_tag_q <= hit_tag_d;
		hit_cat_q <= hit_cat_d;
		status_q  <= status_d;
		out_tag_q <= out_tag_d;
		out_cat_q <= out_cat_d;
		out_cnt_q <= out_cnt_d;
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_tag      = out_tag_q;
	assign out_category = out_cat_q;
	assign entry_count  = spq_pkg::out_count(out_cnt_q);

endmodule

[hdl/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the stable priority queue
// Watches the command and result ports and flags results that cannot
// follow from what was accepted.
// ----------------------------------------------------------------------------
module spq_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic [1:0]                       command,
	input  logic [spq_pkg::TAG_W-1:0]        entry_tag,
	input  logic [spq_pkg::CAT_W-1:0]        category,
	input  logic                             done,
	input  logic [1:0]                       status,
	input  logic [spq_pkg::TAG_W-1:0]        out_tag,
	input  logic [spq_pkg::CAT_W-1:0]        out_category,
	input  logic [spq_pkg::OUT_CNT_W-1:0]    entry_count
);

	// A beat that is not a search is answered in the next cycle.
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command != spq_pkg::CMD_SEARCH) |=> done)
		else $error("non-search beat not answered in the next cycle");

	// No result is shown while a search is running.
	a_quiet_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result shown while busy");

	// A full refusal reports a full queue.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == spq_pkg::ST_FULL) |->
		(entry_count == spq_pkg::out_count(spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH))))
		else $error("full status with wrong entry count");

	// An empty report carries no entry and a zero count.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == spq_pkg::ST_EMPTY) |->
		(out_tag == '0 && out_category == '0 && entry_count == '0))
		else $error("empty status with payload or count");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (.*);

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the stable priority queue
// A driver feeds insert, pop, search and unused commands from a pending
// queue. A monitor keeps its own sorted copy of the queue, predicts every
// result and compares each done beat field by field with the oldest one.
// ----------------------------------------------------------------------------
module tb;

	import spq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 800;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct {
		cmd_t             cmd;
		logic [TAG_W-1:0] tag;
		logic [CAT_W-1:0] cat;
	} queue_cmd_t;

	typedef struct {
		status_t              status;
		logic [TAG_W-1:0]     tag;
		logic [CAT_W-1:0]     cat;
		logic [OUT_CNT_W-1:0] cnt;
	} queue_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	cmd_t                 command = CMD_INSERT;
	logic [TAG_W-1:0]     entry_tag = '0;
	logic [CAT_W-1:0]     category = '0;
	logic                 busy;
	logic                 done;
	logic [1:0]           status;
	logic [TAG_W-1:0]     out_tag;
	logic [CAT_W-1:0]     out_category;
	logic [OUT_CNT_W-1:0] entry_count;

	queue_cmd_t    pending_cmds[$];
	queue_result_t expected_results[$];

	// Shadow copy of the sorted queue.
	logic [TAG_W-1:0] shadow_tag[QUEUE_DEPTH];
	logic [CAT_W-1:0] shadow_cat[QUEUE_DEPTH];
	int               shadow_count = 0;

	int beats_in = 0;
	int issued = 0;
	int quiet_cycles = 0;
	int mismatches = 0;

	stable_priority_queue_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.entry_tag    (entry_tag),
		.category     (category),
		.done         (done),
		.status       (status),
		.out_tag      (out_tag),
		.out_category (out_category),
		.entry_count  (entry_count)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one command to the shadow queue and return the result it gives.
	function automatic queue_result_t apply_queue_cmd(input queue_cmd_t c);
		queue_result_t r;
		int            pos;
		int            i;
		bit            hit;
		r.status = ST_OK;
		r.tag    = '0;
		r.cat    = '0;
		case (c.cmd)
			CMD_INSERT: begin
				if (shadow_count >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// New entry goes behind every entry of equal or lower category.
					pos = 0;
					while (pos < shadow_count && shadow_cat[pos] <= c.cat)
						pos++;
					for (i = shadow_count; i > pos; i--) begin
						shadow_tag[i] = shadow_tag[i-1];
						shadow_cat[i] = shadow_cat[i-1];
					end
					shadow_tag[pos] = c.tag;
					shadow_cat[pos] = c.cat;
					shadow_count++;
				end
			end
			CMD_POP: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.tag = shadow_tag[0];
					r.cat = shadow_cat[0];
					for (i = 1; i < shadow_count; i++) begin
						shadow_tag[i-1] = shadow_tag[i];
						shadow_cat[i-1] = shadow_cat[i];
					end
					shadow_count--;
				end
			end
			CMD_SEARCH: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// The first match from the head wins.
					hit = 1'b0;
					for (i = 0; i < shadow_count && !hit; i++) begin
						if (shadow_tag[i] == c.tag) begin
							r.tag = shadow_tag[i];
							r.cat = shadow_cat[i];
							hit = 1'b1;
						end
					end
					if (!hit)
						r.status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
		r.cnt = OUT_CNT_W'(shadow_count);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic add_cmd(input cmd_t cmd, input logic [TAG_W-1:0] tag,
	                       input logic [CAT_W-1:0] cat);
		queue_cmd_t c;
		c.cmd = cmd;
		c.tag = tag;
		c.cat = cat;
		pending_cmds.push_back(c);
	endtask

	// Driver: hold a beat until it is taken, otherwise idle now and then.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && beats_in < issued) begin
			// Still waiting for the current beat to be taken.
		end else if (pending_cmds.size() > 0 &&
		             ((beats_in >= 300 && beats_in < 450) || $urandom_range(99) >= 20)) begin
			start     <= 1'b1;
			command   <= pending_cmds[0].cmd;
			entry_tag <= pending_cmds[0].tag;
			category  <= pending_cmds[0].cat;
			issued    <= issued + 1;
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: check results, predict accepted beats, and watch for a hang.
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", {30'd0, status}, 32'd0);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
					if (out_tag !== want.tag)
						report_mismatch("out_tag", 32'(out_tag), 32'(want.tag));
					if (out_category !== want.cat)
						report_mismatch("out_category", 32'(out_category), 32'(want.cat));
					if (entry_count !== want.cnt)
						report_mismatch("entry_count", 32'(entry_count), 32'(want.cnt));
				end
			end
			if (start && !busy) begin
				expected_results.push_back(apply_queue_cmd(pending_cmds[0]));
				void'(pending_cmds.pop_front());
				beats_in <= beats_in + 1;
			end
			if (done || (start && !busy))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int   n;
		int   ins_pct;
		int   pick;
		cmd_t cmd;
		logic [TAG_W-1:0] tag;

		// Directed: empty cases, the unused command, filling to the brim,
		// a refused insert, found and missing searches, the unused command, then a pop.
		add_cmd(CMD_POP, 16'h0000, 3'd0);
		add_cmd(CMD_SEARCH, 16'hFFFF, 3'd7);
		add_cmd(CMD_IGNORE, 16'hFFFF, 3'd7);
		add_cmd(CMD_INSERT, 16'hFFFF, 3'd7);
		add_cmd(CMD_INSERT, 16'h0000, 3'd0);
		add_cmd(CMD_INSERT, 16'h1234, 3'd3);
		add_cmd(CMD_INSERT, 16'h5555, 3'd3);
		add_cmd(CMD_INSERT, 16'hAAAA, 3'd3);
		add_cmd(CMD_INSERT, 16'h1234, 3'd1);
		add_cmd(CMD_INSERT, 16'h8001, 3'd7);
		add_cmd(CMD_INSERT, 16'h0001, 3'd0);
		for (n = 0; n < 8; n++)
			add_cmd(CMD_INSERT, 16'(16'h0100 + n), 3'(n));
		add_cmd(CMD_INSERT, 16'hBEEF, 3'd0);
		add_cmd(CMD_SEARCH, 16'h1234, 3'd0);
		add_cmd(CMD_SEARCH, 16'hFFFF, 3'd0);
		add_cmd(CMD_SEARCH, 16'hDEAD, 3'd5);
		add_cmd(CMD_IGNORE, 16'h0000, 3'd0);
		add_cmd(CMD_POP, 16'hFFFF, 3'd7);

		// Random: groups with their own insert bias, so the queue swings
		// between empty and full. Half the tags come from a small pool so
		// searches hit, often on duplicates.
		ins_pct = 50;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				ins_pct = $urandom_range(85, 15);
			pick = $urandom_range(99);
			if (pick < ins_pct)
				cmd = CMD_INSERT;
			else if (pick < ins_pct + (100 - ins_pct) * 5 / 10)
				cmd = CMD_POP;
			else if (pick < ins_pct + (100 - ins_pct) * 9 / 10)
				cmd = CMD_SEARCH;
			else
				cmd = CMD_IGNORE;
			tag = $urandom_range(1) ? 16'($urandom_range(7)) : 16'($urandom_range(65535));
			add_cmd(cmd, tag, 3'($urandom_range(7)));
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Poll once per cycle until every beat is taken and answered.
		while (pending_cmds.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
